FILE: rtl/core/sacl_pkg.sv
// Shared types, constants and helpers for the set-associative LRU cache lookup.
// Used by sacl_store, sacl_lookup and the top level set_assoc_lru_cache_lookup_unit.
// Depends on nothing.
package sacl_pkg;

  // Cache geometry.
  localparam int WAYS      = 4;
  localparam int SET_COUNT = 64;
  localparam int ADDR_BITS = 48;

  // Number of set index bits is floor(log2(SET_COUNT)).
  localparam int SET_BITS = $clog2(SET_COUNT + 1) - 1;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int SETS     = 1 << SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = ADDR_BITS - SET_BITS;

  // Fixed field widths of the ports.
  localparam int OFFSET_W    = 4;
  localparam int WAY_FIELD_W = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 1'd1;

  // Configuration reset values.
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;

  typedef logic [SET_W-1:0]                  set_t;
  typedef logic [WAY_W-1:0]                  way_t;
  typedef logic [TAG_W-1:0]                  tag_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]        tag_row_t;
  typedef logic [WAYS-1:0][WAY_W-1:0]        age_row_t;

  // Contents of one set as seen by the lookup logic.
  typedef struct packed {
    tag_row_t          tags;
    age_row_t          ages;
    logic [WAYS-1:0]   valid;
  } row_t;

  // Update of one set after a lookup.
  typedef struct packed {
    logic     en;
    set_t     set;
    way_t     way;
    tag_row_t tags;
    age_row_t ages;
  } wr_t;

  // Ages after reset: each way starts with its own index.
  function automatic age_row_t reset_ages();
    age_row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w] = WAY_W'(w);
    end
    return r;
  endfunction

  // Way index as the two-bit result field.
  function automatic logic [WAY_FIELD_W-1:0] to_way_field(way_t idx);
    logic [WAY_FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < WAY_FIELD_W && i < WAY_W; i++) begin
      r[i] = idx[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sacl_store.sv
// Tag and age storage for all sets, with per-line valid flip-flops.
// Depends on sacl_pkg. Registered read port, one write port, and a one-entry
// forward of the last write to cover a read issued at the same edge.
module sacl_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  sacl_pkg::set_t   rd_set,
  input  sacl_pkg::wr_t    wr,
  output sacl_pkg::row_t   row
);
  import sacl_pkg::*;

  tag_row_t        tag_mem [SETS];
  age_row_t        age_mem [SETS];
  logic [WAYS-1:0] line_valid [SETS];

  tag_row_t rd_tags;
  age_row_t rd_ages;
  set_t     rd_set_q;

  logic     fwd_valid;
  set_t     fwd_set;
  tag_row_t fwd_tags;
  age_row_t fwd_ages;

  logic use_fwd;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      tag_mem[wr.set] <= wr.tags;
      age_mem[wr.set] <= wr.ages;
    end
    if (rd_en) begin
      rd_tags  <= tag_mem[rd_set];
      rd_ages  <= age_mem[rd_set];
      rd_set_q <= rd_set;
    end
  end

  // Valid bits are flip-flops cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        line_valid[s] <= '0;
      end
    end else if (wr.en) begin
      line_valid[wr.set][wr.way] <= 1'b1;
    end
  end

  // The last write is kept so a read that raced with it sees the new row.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr.en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_set  <= wr.set;
      fwd_tags <= wr.tags;
      fwd_ages <= wr.ages;
    end
  end

  // A set with no valid line was never written, so its ages are the reset ones.
  always_comb begin
    use_fwd   = fwd_valid && (fwd_set == rd_set_q);
    row.valid = line_valid[rd_set_q];
    row.tags  = use_fwd ? fwd_tags : rd_tags;
    if (!(|row.valid)) begin
      row.ages = reset_ages();
    end else begin
      row.ages = use_fwd ? fwd_ages : rd_ages;
    end
  end

endmodule

FILE: rtl/core/sacl_lookup.sv
// Tag compare, victim choice and LRU age update for one set.
// Depends on sacl_pkg. Purely combinational.
module sacl_lookup (
  input  sacl_pkg::row_t     row,
  input  sacl_pkg::tag_t     tag,
  output logic               hit,
  output sacl_pkg::way_t     way,
  output sacl_pkg::tag_row_t tags_next,
  output sacl_pkg::age_row_t ages_next
);
  import sacl_pkg::*;

  localparam way_t OLDEST = WAY_W'(WAYS - 1);

  logic [WAYS-1:0] match;
  logic            found;
  logic            vfound;
  way_t            hit_way;
  way_t            victim;
  way_t            sel;
  way_t            old_age;

  // Parallel compare and lowest-index match.
  always_comb begin
    match   = '0;
    found   = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row.valid[w] && (row.tags[w] == tag);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (match[w] && !found) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Victim is the way holding the oldest age; way 0 if none does.
  always_comb begin
    vfound = 1'b0;
    victim = '0;
    for (int w = 0; w < WAYS; w++) begin
      if ((row.ages[w] == OLDEST) && !vfound) begin
        vfound = 1'b1;
        victim = WAY_W'(w);
      end
    end
  end

  // Selected way becomes most recent; younger ways age by one.
  always_comb begin
    sel     = found ? hit_way : victim;
    old_age = row.ages[sel];
    for (int w = 0; w < WAYS; w++) begin
      if (row.ages[w] < old_age) begin
        ages_next[w] = WAY_W'(row.ages[w] + 1'b1);
      end else begin
        ages_next[w] = row.ages[w];
      end
    end
    ages_next[sel] = '0;
    tags_next      = row.tags;
    if (!found) begin
      tags_next[sel] = tag;
    end
  end

  assign hit = found;
  assign way = sel;

endmodule

FILE: rtl/core/set_assoc_lru_cache_lookup_unit.sv
// Top level of the set-associative tag cache with counter-based LRU.
// Depends on sacl_pkg, sacl_store and sacl_lookup.
//
//   Channel   Signals                       Direction  Transfer when
//   input     in_valid/in_ready, address    in         in_valid & in_ready
//   output    out_valid/out_ready, hit, way out        out_valid & out_ready
//   config    cfg_we, cfg_index, cfg_data   in         cfg_we (no wait)
//
// One access per cycle is sustained while the output does not stall. The set is read from
// the tag/age memories at the input transfer; compare and update happen in the lookup stage,
// which, as it advances, writes the set back and loads the result register.
// A stalled output holds the lookup stage; the input keeps accepting while either is free.
// Reset clears all valid bits at once; there is no clearing pass.
module set_assoc_lru_cache_lookup_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sacl_pkg::ADDR_BITS-1:0]       address,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic [sacl_pkg::WAY_FIELD_W-1:0]     way,
  input  logic                                 cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sacl_pkg::*;

  localparam logic [SET_W-1:0] SET_MASK  = SET_W'((1 << SET_BITS) - 1);
  localparam int               AGE_SUM_W = $clog2(WAYS * WAYS + 1);
  localparam int               AGE_SUM   = (WAYS * (WAYS - 1)) / 2;

  logic                cache_enabled;
  logic [OFFSET_W-1:0] offset_bits;

  logic [ADDR_BITS-1:0] addr_sh;
  set_t                 in_set;
  tag_t                 in_tag;
  logic                 in_xfer;

  logic s1_valid;
  logic s1_en;
  set_t s1_set;
  tag_t s1_tag;
  logic s1_adv;

  row_t     row;
  wr_t      wr;
  logic     lk_hit;
  way_t     lk_way;
  tag_row_t lk_tags;
  age_row_t lk_ages;

  logic [AGE_SUM_W-1:0] age_sum;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_enabled <= 1'b1;
      offset_bits   <= OFFSET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CACHE_ENABLED: cache_enabled <= cfg_data[0];
        REG_OFFSET_BITS:   offset_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address split into set index and tag.
  always_comb begin
    addr_sh = address >> offset_bits;
    in_set  = SET_W'(addr_sh) & SET_MASK;
    in_tag  = TAG_W'(addr_sh >> SET_BITS);
  end

  // Handshake between stages.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // Lookup stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_en  <= cache_enabled;
      s1_set <= in_set;
      s1_tag <= in_tag;
    end
  end

  sacl_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_xfer),
    .rd_set (in_set),
    .wr     (wr),
    .row    (row)
  );

  sacl_lookup u_lookup (
    .row       (row),
    .tag       (s1_tag),
    .hit       (lk_hit),
    .way       (lk_way),
    .tags_next (lk_tags),
    .ages_next (lk_ages)
  );

  // Write back the set only for enabled accesses.
  always_comb begin
    wr.en   = s1_adv && s1_en;
    wr.set  = s1_set;
    wr.way  = lk_way;
    wr.tags = lk_tags;
    wr.ages = lk_ages;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hit <= s1_en && lk_hit;
      way <= s1_en ? to_way_field(lk_way) : '0;
    end
  end

  // Sum of the ages seen by the lookup stage.
  always_comb begin
    age_sum = '0;
    for (int w = 0; w < WAYS; w++) begin
      age_sum = AGE_SUM_W'(age_sum + AGE_SUM_W'(row.ages[w]));
    end
  end

  // The ages of a set stay a permutation, so their sum is fixed.
  a_age_perm: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_en |-> age_sum == AGE_SUM_W'(AGE_SUM))
    else $error("age row of the looked-up set is not a permutation");

  // A hit always names a way whose valid bit is set.
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_en && lk_hit |-> row.valid[lk_way])
    else $error("hit on a way that is not valid");

  // An accepted access occupies the lookup stage in the next cycle.
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted access lost before lookup");

  // With the result register empty the input is never blocked.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

endmodule
